// File: sv/fwc_pkg.sv
`timescale 1ns / 1ps
// Package for the FIR filter with output clamp: widths, register indexes,
// coefficient table and the control structs shared by the modules.
// No dependencies.
package fwc_pkg;

  localparam int TAPS      = 52;
  localparam int BLOCK_LEN = 64;
  localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int BLK_W     = 8;

  localparam int SAMPLE_W = 16;
  localparam int CELL_W   = 18;
  localparam int COEF_W   = 20;
  localparam int ACC_W    = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_W     = 32;
  localparam int DIVS_W    = 16;
  localparam int DIV_CNT_W = 5;
  localparam int IN_DIV_STEPS  = 17;
  localparam int OUT_DIV_STEPS = 31;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_DIVISOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_DIVISOR = 2'd2;

  localparam logic [SAMPLE_W-1:0] OUT_MAX = 16'hFFFF;

  localparam logic signed [COEF_W-1:0] COEF_TABLE [52] = '{
    20'sd0, -20'sd63, -20'sd278, -20'sd552, -20'sd614, -20'sd68, 20'sd1445, 20'sd3997,
    20'sd7119, 20'sd9635, 20'sd9756, 20'sd5509, -20'sd4490, -20'sd20096, -20'sd38816,
    -20'sd55509, -20'sd62878, -20'sd52858, -20'sd18704, 20'sd42740, 20'sd129254,
    20'sd232586, 20'sd339327, 20'sd433272, 20'sd498780, 20'sd524286, 20'sd505032,
    20'sd444227, 20'sd352326, 20'sd244605, 20'sd137715, 20'sd46149, -20'sd20474,
    -20'sd58683, -20'sd70839, -20'sd63503, -20'sd45126, -20'sd23764, -20'sd5408,
    20'sd6767, 20'sd12246, 20'sd12390, 20'sd9412, 20'sd5462, 20'sd2057, -20'sd102,
    -20'sd998, -20'sd1015, -20'sd641, -20'sd257, -20'sd46, 20'sd0
  };

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

endpackage

// File: sv/fwc_in_if.sv
`timescale 1ns / 1ps
// Input channel of the FIR filter: valid, ready and one raw sample.
// Depends on fwc_pkg.
interface fwc_in_if;
  import fwc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: sv/fwc_out_if.sv
`timescale 1ns / 1ps
// Output channel of the FIR filter: valid, ready, one result item and a block-done flag.
// Depends on fwc_pkg.
interface fwc_out_if;
  import fwc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] filtered;
  logic                block_done;

  modport source (output valid, output filtered, output block_done, input ready);
  modport sink (input valid, input filtered, input block_done, output ready);
endinterface

// File: sv/fwc_cell.sv
`timescale 1ns / 1ps
// One cell of the delay ring: holds one scaled sample and takes its left
// neighbor on a shift or its right neighbor on a rotate. Depends on fwc_pkg.
module fwc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fwc_pkg::cell_ctrl_t        ctrl_i,
  input  logic [fwc_pkg::CELL_W-1:0] left_i,
  input  logic [fwc_pkg::CELL_W-1:0] right_i,
  output logic [fwc_pkg::CELL_W-1:0] val_o
);
  import fwc_pkg::*;

  logic [CELL_W-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      priority if (ctrl_i.shift) begin
        val_q <= left_i;
      end else if (ctrl_i.rotate) begin
        val_q <= right_i;
      end else begin
        val_q <= val_q;
      end
    end
  end

  assign val_o = val_q;
endmodule

// File: sv/fwc_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider shared by the input and output scaling.
// The dividend is left-aligned; one quotient bit per cycle. Depends on fwc_pkg.
module fwc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fwc_pkg::div_req_t          req_i,
  input  logic [fwc_pkg::DIV_W-1:0]  dividend_i,
  input  logic [fwc_pkg::DIVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [fwc_pkg::DIV_W-1:0]  quotient_o
);
  import fwc_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIVS_W-1:0]    rem_q;
  logic [DIVS_W-1:0]    dvs_q;
  logic [DIVS_W:0]      rem_sh;
  logic                 fits;
  logic [DIVS_W:0]      rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
  assign fits    = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// File: sv/fir_filter_with_output_clamp_unit.sv
`timescale 1ns / 1ps
// FIR filter with input scaling and output clamp, top level.
// One item at a time: an accepted item passes the input divide, the MAC around the cell
// ring, the close of the sum, the output divide and the load of the output; a negative
// sum skips the output divide and gives zero. The next item is accepted once the unit is
// back in idle, after any wait for the result port.
// Reset clears the delay ring and presets the block counter and config registers; no sweep.
module fir_filter_with_output_clamp_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fwc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fwc_pkg::CFG_W-1:0]     cfg_wdata_i,
  fwc_in_if.sink                        sample_i,
  fwc_out_if.source                     result_o
);
  import fwc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_IDIV = 6'b000010,
    S_MAC  = 6'b000100,
    S_ACC  = 6'b001000,
    S_ODIV = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] in_offset_q;
  logic [CFG_W-1:0] in_div_q;
  logic [CFG_W-1:0] out_div_q;

  logic [TAP_W-1:0]  k_q;
  logic              prod_vld_q;
  logic [ACC_W-1:0]  prod_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  acc_next;
  logic              x_neg_q;
  logic [SAMPLE_W-1:0] res_q;
  logic [BLK_W-1:0]  blk_q;
  logic [BLK_W-1:0]  blk_dec;
  logic              out_vld_q;
  logic [SAMPLE_W-1:0] out_filt_q;
  logic              out_done_q;

  logic              accept;
  logic signed [CELL_W-1:0] x_raw;
  logic [CELL_W-2:0] x_mag;
  logic [CELL_W-1:0] x_new;
  logic [CELL_W-2:0] q_in;

  div_req_t          div_req;
  logic [DIV_W-1:0]  div_dvd;
  logic [DIVS_W-1:0] div_dvs;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  cell_ctrl_t        cell_ctrl;
  logic [CELL_W-1:0] cells [TAPS];
  logic signed [CELL_W+COEF_W-1:0] prod_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_offset_q <= '0;
      in_div_q    <= CFG_W'(1);
      out_div_q   <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INPUT_OFFSET:   in_offset_q <= cfg_wdata_i;
        REG_INPUT_DIVISOR:  in_div_q    <= cfg_wdata_i;
        REG_OUTPUT_DIVISOR: out_div_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign accept          = sample_i.valid && sample_i.ready;
  assign sample_i.ready  = (state_q == S_IDLE);

  assign x_raw = $signed({2'b00, sample_i.sample}) +
                 $signed({{(CELL_W-CFG_W){in_offset_q[CFG_W-1]}}, in_offset_q});
  assign x_mag = x_raw[CELL_W-1] ? (CELL_W-1)'(-x_raw) : x_raw[CELL_W-2:0];

  assign acc_next = acc_q + prod_q;

  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = DIV_CNT_W'(IN_DIV_STEPS);
    div_dvd       = {x_mag, {(DIV_W-CELL_W+1){1'b0}}};
    div_dvs       = (in_div_q == '0) ? DIVS_W'(1) : in_div_q;
    if (accept) begin
      div_req.start = 1'b1;
    end else if (state_q == S_ACC && !acc_next[ACC_W-1]) begin
      div_req.start = 1'b1;
      div_req.steps = DIV_CNT_W'(OUT_DIV_STEPS);
      div_dvd       = {acc_next[ACC_W-2:0], 1'b0};
      div_dvs       = (out_div_q == '0) ? DIVS_W'(1) : out_div_q;
    end
  end

  fwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign q_in  = div_quo[CELL_W-2:0];
  assign x_new = x_neg_q ? CELL_W'(-{1'b0, q_in}) : {1'b0, q_in};

  assign cell_ctrl.shift  = (state_q == S_IDIV) && div_done;
  assign cell_ctrl.rotate = (state_q == S_MAC);

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    fwc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .left_i  ((i == 0) ? x_new : cells[(i + TAPS - 1) % TAPS]),
      .right_i (cells[(i + 1) % TAPS]),
      .val_o   (cells[i])
    );
  end

  assign prod_full = $signed(cells[0]) * COEF_TABLE[k_q];
  assign blk_dec   = blk_q - 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_IDIV;
      S_IDIV: if (div_done) state_d = S_MAC;
      S_MAC:  if (k_q == TAP_W'(TAPS - 1)) state_d = S_ACC;
      S_ACC:  state_d = acc_next[ACC_W-1] ? S_EMIT : S_ODIV;
      S_ODIV: if (div_done) state_d = S_EMIT;
      S_EMIT: if (!out_vld_q || result_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      prod_vld_q <= 1'b0;
      blk_q      <= BLK_W'(BLOCK_LEN);
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      prod_vld_q <= (state_q == S_MAC);
      if (state_q == S_MAC && k_q != TAP_W'(TAPS - 1)) begin
        k_q <= k_q + 1'b1;
      end else begin
        k_q <= '0;
      end
      if (out_vld_q && result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == S_EMIT && (!out_vld_q || result_o.ready)) begin
        out_vld_q <= 1'b1;
        blk_q     <= (blk_dec == '0) ? BLK_W'(BLOCK_LEN) : blk_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_neg_q <= x_raw[CELL_W-1];
    end
    if (state_q == S_MAC) begin
      prod_q <= prod_full[ACC_W-1:0];
    end
    if (state_q == S_IDIV) begin
      acc_q <= '0;
    end else if (state_q == S_MAC && prod_vld_q) begin
      acc_q <= acc_next;
    end
    if (state_q == S_ACC) begin
      res_q <= '0;
    end else if (state_q == S_ODIV && div_done) begin
      res_q <= (div_quo[DIV_W-1:SAMPLE_W] != '0) ? OUT_MAX : div_quo[SAMPLE_W-1:0];
    end
    if (state_q == S_EMIT && (!out_vld_q || result_o.ready)) begin
      out_filt_q <= res_q;
      out_done_q <= (blk_dec == '0);
    end
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.filtered   = out_filt_q;
  assign result_o.block_done = out_done_q;

`ifndef SYNTHESIS
  a_div_done_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_IDIV || state_q == S_ODIV))
    else $error("divider finished outside a divide phase");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_IDIV))
    else $error("accepted item did not start the input divide");

  a_last_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (prod_vld_q && $past(k_q) == TAP_W'(TAPS - 1)))
    else $error("sum closed before the last product");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_vld_q) |=> (out_vld_q && state_q == S_IDLE))
    else $error("result not moved to the output register");
`endif
endmodule
